[hw/rtl/vfm_pkg.sv]
package vfm_pkg;

   localparam int GRID_BITS_DEFAULT = 5;
   localparam int COORD_W           = 5;
   localparam int KIND_W            = 3;
   localparam int MASK_W            = 6;
   localparam int STEP_W            = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [KIND_W-1:0] KIND_AIR = '0;

   // read sequence of a query: center first, then faces in mask bit order
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_ZP     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ZN     = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YP     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YN     = 3'd4;
   localparam logic [STEP_W-1:0] STEP_XN     = 3'd5;
   localparam logic [STEP_W-1:0] STEP_XP     = 3'd6;

   typedef struct packed {
      logic              cmd;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [KIND_W-1:0]  block_kind;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] cell_kind;
      logic [MASK_W-1:0] face_mask;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

   typedef struct packed {
      logic clearing;
   } store_status_type;

endpackage

[hw/rtl/voxel_exposed_face_mask_top.sv]
// Voxel exposed-face mask unit.
// Keeps a cubic grid of 2^GRID_BITS cells per side, 3-bit block type per cell.
// Request channel: a transaction is taken at a rising edge with start high and
//   busy low. cmd = write stores block_kind at (pos_x, pos_y, pos_z) and gives
//   no response; cmd = query gives one response.
// Response channel: rsp_valid is high for exactly one cycle with rsp_item
//   holding the cell type and six exposed-face bits; the receiver cannot stall.
// Timing: a write keeps busy high through the S_WRITE state after it is taken.
//   A query does seven reads of the single-ported voxel memory (center plus
//   six neighbors, one per cycle), then waits in S_DRAIN for the last read to
//   return; rsp_valid rises in the same cycle busy drops, and the next
//   transaction is taken only after that, so one query is handled at a time.
//   The memory port sets the pace of a query.
// Reset: every cell is swept to empty air, one cell per cycle, across all
//   2^(3*GRID_BITS) cells (32768 at the default); busy stays high meanwhile.
module voxel_exposed_face_mask_top #(
   parameter int GRID_BITS = vfm_pkg::GRID_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  vfm_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output vfm_pkg::rsp_type rsp_item
);

   vfm_pkg::mem_cmd_type         mem_cmd;
   logic [3*GRID_BITS-1:0]       mem_addr;
   logic [vfm_pkg::KIND_W-1:0]   mem_wdata;
   logic [vfm_pkg::KIND_W-1:0]   mem_rdata;
   vfm_pkg::store_status_type    status;

   // sequencer: takes transactions, walks center and neighbor reads, builds mask
   vfm_ctrl #(
      .GRID_BITS (GRID_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .status    (status),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // voxel memory with its post-reset clearing sweep
   vfm_store #(
      .GRID_BITS (GRID_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .status    (status)
   );

endmodule

[hw/rtl/vfm_store.sv]
module vfm_store #(
   parameter int GRID_BITS = vfm_pkg::GRID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vfm_pkg::mem_cmd_type          mem_cmd,
   input  logic [3*GRID_BITS-1:0]        mem_addr,
   input  logic [vfm_pkg::KIND_W-1:0]    mem_wdata,
   output logic [vfm_pkg::KIND_W-1:0]    mem_rdata,
   output vfm_pkg::store_status_type     status
);

   localparam int AddrW = 3 * GRID_BITS;
   localparam int Depth = 1 << AddrW;

   logic [vfm_pkg::KIND_W-1:0] voxel_mem [Depth];

   logic             clr_ff, clr_in;
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;
   logic [vfm_pkg::KIND_W-1:0] rd_data_ff;

   // clearing sweep, one cell per cycle after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AddrW'(1);
         if (clr_addr_ff == '1) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         voxel_mem[clr_addr_ff] <= vfm_pkg::KIND_AIR;
      end else if (mem_cmd.wr_en) begin
         voxel_mem[mem_addr] <= mem_wdata;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= voxel_mem[mem_addr];
      end
   end

   assign mem_rdata       = rd_data_ff;
   assign status.clearing = clr_ff;

endmodule

[hw/rtl/vfm_ctrl.sv]
module vfm_ctrl #(
   parameter int GRID_BITS = vfm_pkg::GRID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  vfm_pkg::req_type              req_item,
   output logic                          busy,
   output logic                          rsp_valid,
   output vfm_pkg::rsp_type              rsp_item,
   input  vfm_pkg::store_status_type     status,
   output vfm_pkg::mem_cmd_type          mem_cmd,
   output logic [3*GRID_BITS-1:0]        mem_addr,
   output logic [vfm_pkg::KIND_W-1:0]    mem_wdata,
   input  logic [vfm_pkg::KIND_W-1:0]    mem_rdata
);

   // coordinate width with room for +1 and wrap of -1 beyond the grid
   localparam int CoordW = ((GRID_BITS > vfm_pkg::COORD_W) ? GRID_BITS : vfm_pkg::COORD_W) + 1;
   localparam logic [CoordW-1:0] GridSize = CoordW'(1) << GRID_BITS;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WRITE = 4'b0010,
      S_READ  = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   vfm_pkg::req_type                  item_ff, item_in;
   logic [vfm_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                              rd_pend_ff, rd_pend_in;
   logic [vfm_pkg::STEP_W-1:0]        rd_step_ff, rd_step_in;
   logic                              rd_out_ff, rd_out_in;
   logic [vfm_pkg::KIND_W-1:0]        kind_ff, kind_in;
   logic [vfm_pkg::MASK_W-1:0]        empty_ff, empty_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   vfm_pkg::rsp_type                  rsp_item_ff, rsp_item_in;

   logic [CoordW-1:0]          cx, cy, cz, nx, ny, nz;
   logic                       n_inside;
   logic                       nb_empty;
   logic [vfm_pkg::STEP_W-1:0] face_idx;

   assign busy = status.clearing | (state_ff != S_IDLE);

   // neighbor position for the current step
   always_comb begin
      cx = CoordW'(item_ff.pos_x);
      cy = CoordW'(item_ff.pos_y);
      cz = CoordW'(item_ff.pos_z);
      nx = cx;
      ny = cy;
      nz = cz;
      unique case (step_ff)
         vfm_pkg::STEP_ZP: nz = cz + CoordW'(1);
         vfm_pkg::STEP_ZN: nz = cz - CoordW'(1);
         vfm_pkg::STEP_YP: ny = cy + CoordW'(1);
         vfm_pkg::STEP_YN: ny = cy - CoordW'(1);
         vfm_pkg::STEP_XN: nx = cx - CoordW'(1);
         vfm_pkg::STEP_XP: nx = cx + CoordW'(1);
         default: ;
      endcase
      n_inside = (nx < GridSize) && (ny < GridSize) && (nz < GridSize);
   end

   assign mem_addr      = {nx[GRID_BITS-1:0], ny[GRID_BITS-1:0], nz[GRID_BITS-1:0]};
   assign mem_wdata     = item_ff.block_kind;
   assign mem_cmd.wr_en = (state_ff == S_WRITE) && n_inside;
   assign mem_cmd.rd_en = (state_ff == S_READ) && n_inside;

   // returning read data
   assign nb_empty = rd_out_ff | (mem_rdata == vfm_pkg::KIND_AIR);
   assign face_idx = rd_step_ff - vfm_pkg::STEP_W'(1);

   always_comb begin
      kind_in  = kind_ff;
      empty_in = empty_ff;
      if (rd_pend_ff) begin
         if (rd_step_ff == vfm_pkg::STEP_CENTER) begin
            kind_in = rd_out_ff ? vfm_pkg::KIND_AIR : mem_rdata;
         end else begin
            empty_in[face_idx] = nb_empty;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      rd_pend_in   = (state_ff == S_READ);
      rd_step_in   = step_ff;
      rd_out_in    = !n_inside;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               item_in  = req_item;
               step_in  = vfm_pkg::STEP_CENTER;
               state_in = (req_item.cmd == vfm_pkg::CMD_WRITE) ? S_WRITE : S_READ;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         S_READ: begin
            step_in = step_ff + vfm_pkg::STEP_W'(1);
            if (step_ff == vfm_pkg::STEP_XP) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in              = S_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_item_in.cell_kind = kind_ff;
            rsp_item_in.face_mask = (kind_ff != vfm_pkg::KIND_AIR) ? empty_in : '0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      step_ff     <= step_in;
      rd_step_ff  <= rd_step_in;
      rd_out_ff   <= rd_out_in;
      kind_ff     <= kind_in;
      empty_ff    <= empty_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
